### hdl/bon_pkg.sv
package bon_pkg;

    // Q2.30 result component and a three-component vector of them
    typedef logic signed [31:0] q30_t;
    typedef q30_t [2:0] vec_t;

    // Square root and divider depth, two result bits per stage
    localparam int ISQ_STG = 16;
    localparam int DIV_STG = 16;

    // Normalizer: magnitude/max, leading one, shift, square, sum,
    // root stages, divider setup, divider stages, sign
    localparam int NORM_LAT = 5 + ISQ_STG + 1 + DIV_STG + 1;
    localparam int PROJ_LAT = 5;
    localparam int CROSS_LAT = 2;

    // Widths of the orthogonalized up vector and of the raw cross product
    localparam int W_W = 34;
    localparam int C_W = 65;

endpackage

### hdl/bon_in_if.sv
interface bon_in_if #(parameter int IN_WIDTH = 32) ();
    logic                       valid;
    logic                       ready;
    logic signed [IN_WIDTH-1:0] right_x;
    logic signed [IN_WIDTH-1:0] right_y;
    logic signed [IN_WIDTH-1:0] right_z;
    logic signed [IN_WIDTH-1:0] up_x;
    logic signed [IN_WIDTH-1:0] up_y;
    logic signed [IN_WIDTH-1:0] up_z;

    modport source (output valid, right_x, right_y, right_z, up_x, up_y, up_z, input ready);
    modport sink (input valid, right_x, right_y, right_z, up_x, up_y, up_z, output ready);
endinterface

### hdl/bon_out_if.sv
interface bon_out_if ();
    logic               valid;
    logic               ready;
    logic signed [31:0] out_right_x;
    logic signed [31:0] out_right_y;
    logic signed [31:0] out_right_z;
    logic signed [31:0] out_up_x;
    logic signed [31:0] out_up_y;
    logic signed [31:0] out_up_z;
    logic signed [31:0] out_fwd_x;
    logic signed [31:0] out_fwd_y;
    logic signed [31:0] out_fwd_z;
    logic               degenerate;

    modport source (output valid, out_right_x, out_right_y, out_right_z, out_up_x, out_up_y,
                    out_up_z, out_fwd_x, out_fwd_y, out_fwd_z, degenerate, input ready);
    modport sink (input valid, out_right_x, out_right_y, out_right_z, out_up_x, out_up_y,
                  out_up_z, out_fwd_x, out_fwd_y, out_fwd_z, degenerate, output ready);
endinterface

### hdl/bon_delay.sv
module bon_delay #(
    parameter int W   = 1,
    parameter int LAT = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);
    logic [W-1:0] line_reg [LAT];

    // Side data that rides along with a pipelined unit
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= d;
            for (int k = 1; k < LAT; k++)
            begin
                line_reg[k] <= line_reg[k-1];
            end
        end
    end

    assign q = line_reg[LAT-1];
endmodule

### hdl/bon_norm3.sv
module bon_norm3 #(
    parameter int VW = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [2:0][VW-1:0]  vec,
    output logic                out_valid,
    output bon_pkg::vec_t       res,
    output logic                zero
);
    import bon_pkg::*;

    localparam int LW = $clog2(VW + 1);

    typedef struct packed {
        logic [35:0]      rem;
        logic [31:0]      root;
        logic [63:0]      x;
        logic [2:0][29:0] m;
        logic [2:0]       neg;
        logic             zero;
    } sq_t;

    typedef struct packed {
        logic [30:0]      n;
        logic [2:0][31:0] num;
        logic [2:0][32:0] rem;
        logic [2:0][31:0] q;
        logic [2:0]       neg;
        logic             zero;
    } dv_t;

    // One digit of the restoring square root
    function automatic sq_t sq_digit(input sq_t a);
        sq_t         b;
        logic [35:0] r2;
        logic [35:0] tr;
        b  = a;
        r2 = {a.rem[33:0], a.x[63:62]};
        tr = {2'b00, a.root, 2'b01};
        if (r2 >= tr)
        begin
            b.rem  = r2 - tr;
            b.root = {a.root[30:0], 1'b1};
        end
        else
        begin
            b.rem  = r2;
            b.root = {a.root[30:0], 1'b0};
        end
        b.x = {a.x[61:0], 2'b00};
        return b;
    endfunction

    // One quotient bit for all three lanes
    function automatic dv_t dv_digit(input dv_t a);
        dv_t         b;
        logic [32:0] r2;
        b = a;
        for (int i = 0; i < 3; i++)
        begin
            r2 = {a.rem[i][31:0], a.num[i][31]};
            if (r2 >= {2'b00, a.n})
            begin
                b.rem[i] = r2 - {2'b00, a.n};
                b.q[i]   = {a.q[i][30:0], 1'b1};
            end
            else
            begin
                b.rem[i] = r2;
                b.q[i]   = {a.q[i][30:0], 1'b0};
            end
            b.num[i] = {a.num[i][30:0], 1'b0};
        end
        return b;
    endfunction

    logic [2:0][VW-1:0] a_mag_next, a_mag_reg, b_mag_reg;
    logic [VW-1:0]      a_max_next, a_max_reg;
    logic [2:0]         a_neg_reg, b_neg_reg, c_neg_reg, d_neg_reg, e_neg_reg;
    logic [LW-1:0]      b_len_next, b_len_reg;
    logic               b_zero_reg, c_zero_reg, d_zero_reg, e_zero_reg;
    logic [2:0][29:0]   c_m_next, c_m_reg, d_m_reg, e_m_reg;
    logic [2:0][59:0]   d_sq_reg;
    logic [61:0]        e_sum_reg;
    logic               a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg, e_vld_reg;
    sq_t                e_sq;
    sq_t                sq_reg [ISQ_STG];
    logic [ISQ_STG-1:0] sq_vld_reg;
    dv_t                p_dv_next, p_dv_reg;
    logic               p_vld_reg;
    dv_t                dv_reg [DIV_STG];
    logic [DIV_STG-1:0] dv_vld_reg;
    vec_t               res_next, res_reg;
    logic               zero_reg, out_valid_reg;
    logic [VW+29:0]     sh;
    logic [61:0]        full;

    // Magnitudes and the largest one
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_mag_next[i] = vec[i][VW-1] ? (~vec[i] + 1'b1) : vec[i];
        end
        a_max_next = (a_mag_next[0] > a_mag_next[1]) ? a_mag_next[0] : a_mag_next[1];
        if (a_mag_next[2] > a_max_next)
        begin
            a_max_next = a_mag_next[2];
        end
    end

    // Bit length of the largest magnitude
    always_comb
    begin
        b_len_next = '0;
        for (int i = 0; i < VW; i++)
        begin
            if (a_max_reg[i])
            begin
                b_len_next = LW'(i + 1);
            end
        end
    end

    // Scale so that the largest magnitude lands in [2^29, 2^30)
    always_comb
    begin
        sh = '0;
        for (int i = 0; i < 3; i++)
        begin
            sh          = {b_mag_reg[i], 30'b0} >> b_len_reg;
            c_m_next[i] = sh[29:0];
        end
    end

    // Root pipeline input
    always_comb
    begin
        e_sq      = '0;
        e_sq.x    = {2'b00, e_sum_reg};
        e_sq.m    = e_m_reg;
        e_sq.neg  = e_neg_reg;
        e_sq.zero = e_zero_reg;
    end

    // Divider setup: dividend m * 2^30 + n/2 per lane
    always_comb
    begin
        full           = '0;
        p_dv_next      = '0;
        p_dv_next.n    = sq_reg[ISQ_STG-1].root[30:0];
        p_dv_next.neg  = sq_reg[ISQ_STG-1].neg;
        p_dv_next.zero = sq_reg[ISQ_STG-1].zero;
        for (int i = 0; i < 3; i++)
        begin
            full = {2'b00, sq_reg[ISQ_STG-1].m[i], 30'b0}
                 + 62'(sq_reg[ISQ_STG-1].root[30:1]);
            p_dv_next.num[i] = full[31:0];
            p_dv_next.rem[i] = {3'b000, full[61:32]};
        end
    end

    // Sign and zero-length override
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dv_reg[DIV_STG-1].zero)
            begin
                res_next[i] = '0;
            end
            else if (dv_reg[DIV_STG-1].neg[i])
            begin
                res_next[i] = -dv_reg[DIV_STG-1].q[i];
            end
            else
            begin
                res_next[i] = dv_reg[DIV_STG-1].q[i];
            end
        end
    end

    // Data path registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mag_reg  <= a_mag_next;
            a_max_reg  <= a_max_next;
            for (int i = 0; i < 3; i++)
            begin
                a_neg_reg[i] <= vec[i][VW-1];
                d_sq_reg[i]  <= 60'(c_m_reg[i]) * 60'(c_m_reg[i]);
            end
            b_mag_reg  <= a_mag_reg;
            b_neg_reg  <= a_neg_reg;
            b_len_reg  <= b_len_next;
            b_zero_reg <= (a_max_reg == '0);
            c_m_reg    <= c_m_next;
            c_neg_reg  <= b_neg_reg;
            c_zero_reg <= b_zero_reg;
            d_m_reg    <= c_m_reg;
            d_neg_reg  <= c_neg_reg;
            d_zero_reg <= c_zero_reg;
            e_sum_reg  <= 62'(d_sq_reg[0]) + 62'(d_sq_reg[1]) + 62'(d_sq_reg[2]);
            e_m_reg    <= d_m_reg;
            e_neg_reg  <= d_neg_reg;
            e_zero_reg <= d_zero_reg;
            sq_reg[0]  <= sq_digit(sq_digit(e_sq));
            for (int s = 1; s < ISQ_STG; s++)
            begin
                sq_reg[s] <= sq_digit(sq_digit(sq_reg[s-1]));
            end
            p_dv_reg  <= p_dv_next;
            dv_reg[0] <= dv_digit(dv_digit(p_dv_reg));
            for (int s = 1; s < DIV_STG; s++)
            begin
                dv_reg[s] <= dv_digit(dv_digit(dv_reg[s-1]));
            end
            res_reg  <= res_next;
            zero_reg <= dv_reg[DIV_STG-1].zero;
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg     <= 1'b0;
            b_vld_reg     <= 1'b0;
            c_vld_reg     <= 1'b0;
            d_vld_reg     <= 1'b0;
            e_vld_reg     <= 1'b0;
            sq_vld_reg    <= '0;
            p_vld_reg     <= 1'b0;
            dv_vld_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg     <= in_valid;
            b_vld_reg     <= a_vld_reg;
            c_vld_reg     <= b_vld_reg;
            d_vld_reg     <= c_vld_reg;
            e_vld_reg     <= d_vld_reg;
            sq_vld_reg    <= {sq_vld_reg[ISQ_STG-2:0], e_vld_reg};
            p_vld_reg     <= sq_vld_reg[ISQ_STG-1];
            dv_vld_reg    <= {dv_vld_reg[DIV_STG-2:0], p_vld_reg};
            out_valid_reg <= dv_vld_reg[DIV_STG-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;
    assign zero      = zero_reg;
endmodule

### hdl/bon_proj.sv
module bon_proj (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  bon_pkg::vec_t               r,
    input  bon_pkg::vec_t               un,
    output logic                        out_valid,
    output logic [2:0][bon_pkg::W_W-1:0] w,
    output bon_pkg::vec_t               r_out
);
    import bon_pkg::*;

    // Q4.60 to Q2.30, half away from zero
    function automatic logic signed [35:0] rnd(input logic signed [65:0] x);
        logic [65:0] mag;
        logic [65:0] q;
        mag = x[65] ? 66'(-x) : 66'(x);
        q   = (mag + 66'(1 << 29)) >> 30;
        return x[65] ? -36'(q) : 36'(q);
    endfunction

    logic signed [63:0] p1_reg [3];
    logic signed [65:0] dot_reg;
    logic signed [35:0] d_reg;
    logic signed [65:0] t_reg [3];
    logic [2:0][W_W-1:0] w_reg;
    vec_t r1_reg, r2_reg, r3_reg, r4_reg, r5_reg;
    vec_t u1_reg, u2_reg, u3_reg, u4_reg;
    logic [PROJ_LAT-1:0] vld_reg;

    // Dot product, rounded coefficient, then the projection removed
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p1_reg[i] <= 64'($signed(r[i])) * 64'($signed(un[i]));
                t_reg[i]  <= 66'($signed(r3_reg[i])) * 66'(d_reg);
                w_reg[i]  <= W_W'(36'($signed(u4_reg[i])) - rnd(t_reg[i]));
            end
            dot_reg <= 66'(p1_reg[0]) + 66'(p1_reg[1]) + 66'(p1_reg[2]);
            d_reg   <= rnd(dot_reg);
            r1_reg  <= r;
            r2_reg  <= r1_reg;
            r3_reg  <= r2_reg;
            r4_reg  <= r3_reg;
            r5_reg  <= r4_reg;
            u1_reg  <= un;
            u2_reg  <= u1_reg;
            u3_reg  <= u2_reg;
            u4_reg  <= u3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PROJ_LAT-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[PROJ_LAT-1];
    assign w         = w_reg;
    assign r_out     = r5_reg;
endmodule

### hdl/bon_cross.sv
module bon_cross (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  bon_pkg::vec_t                r,
    input  bon_pkg::vec_t                u,
    output logic                         out_valid,
    output logic [2:0][bon_pkg::C_W-1:0] c,
    output bon_pkg::vec_t                r_out,
    output bon_pkg::vec_t                u_out
);
    import bon_pkg::*;

    logic signed [63:0]  pr_reg [3][3];
    logic [2:0][C_W-1:0] c_reg;
    vec_t                r1_reg, r2_reg, u1_reg, u2_reg;
    logic [CROSS_LAT-1:0] vld_reg;

    // All pairwise products, then the three differences
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    pr_reg[i][j] <= 64'($signed(r[i])) * 64'($signed(u[j]));
                end
            end
            c_reg[0] <= C_W'(pr_reg[1][2]) - C_W'(pr_reg[2][1]);
            c_reg[1] <= C_W'(pr_reg[2][0]) - C_W'(pr_reg[0][2]);
            c_reg[2] <= C_W'(pr_reg[0][1]) - C_W'(pr_reg[1][0]);
            r1_reg   <= r;
            r2_reg   <= r1_reg;
            u1_reg   <= u;
            u2_reg   <= u1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[CROSS_LAT-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[CROSS_LAT-1];
    assign c         = c_reg;
    assign r_out     = r2_reg;
    assign u_out     = u2_reg;
endmodule

### hdl/rotation_basis_orthonormalizer_unit.sv
// Throughput: one transaction per cycle unless the result stalls; each normalizer's
// square root and dividers are unrolled into register stages, two result bits per stage.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// Reset (async, active low) clears only the valid bits; the data path is not reset.
module rotation_basis_orthonormalizer_unit #(
    parameter int IN_WIDTH = 32
) (
    input logic       clk,
    input logic       rst_n,
    bon_in_if.sink    item,
    bon_out_if.source result
);
    import bon_pkg::*;

    logic                     en;
    logic [2:0][IN_WIDTH-1:0] rin, uin;
    logic                     nr_vld, pj_vld, nw_vld, cx_vld, nf_vld;
    vec_t                     r1, un1, r2, r3, u3, r4, u4, r5, u5, f5;
    logic                     r1_zero, u1_zero, u3_zero, f_zero;
    logic                     deg2, deg3a, deg4, deg5;
    logic [2:0][W_W-1:0]      w;
    logic [2:0][C_W-1:0]      c;
    vec_t                     r_reg, u_reg, f_reg;
    logic                     deg_reg, out_valid_reg;

    // Global advance: move whenever the output slot is free or being taken
    assign en         = !out_valid_reg || result.ready;
    assign item.ready = en;

    assign rin = {item.right_z, item.right_y, item.right_x};
    assign uin = {item.up_z, item.up_y, item.up_x};

    // Right and up normalized side by side
    bon_norm3 #(.VW(IN_WIDTH)) u_nr (
        .clk, .rst_n, .en, .in_valid(item.valid), .vec(rin),
        .out_valid(nr_vld), .res(r1), .zero(r1_zero));

    bon_norm3 #(.VW(IN_WIDTH)) u_nu (
        .clk, .rst_n, .en, .in_valid(item.valid), .vec(uin),
        .out_valid(), .res(un1), .zero(u1_zero));

    bon_delay #(.W(1), .LAT(PROJ_LAT)) u_d1 (
        .clk, .en, .d(r1_zero | u1_zero), .q(deg2));

    // Remove the projection on right
    bon_proj u_proj (
        .clk, .rst_n, .en, .in_valid(nr_vld), .r(r1), .un(un1),
        .out_valid(pj_vld), .w(w), .r_out(r2));

    bon_norm3 #(.VW(W_W)) u_nw (
        .clk, .rst_n, .en, .in_valid(pj_vld), .vec(w),
        .out_valid(nw_vld), .res(u3), .zero(u3_zero));

    bon_delay #(.W(97), .LAT(NORM_LAT)) u_d2 (
        .clk, .en, .d({r2, deg2}), .q({r3, deg3a}));

    // Forward from the cross product
    bon_cross u_cross (
        .clk, .rst_n, .en, .in_valid(nw_vld), .r(r3), .u(u3),
        .out_valid(cx_vld), .c(c), .r_out(r4), .u_out(u4));

    bon_delay #(.W(1), .LAT(CROSS_LAT)) u_d3 (
        .clk, .en, .d(deg3a | u3_zero), .q(deg4));

    bon_norm3 #(.VW(C_W)) u_nf (
        .clk, .rst_n, .en, .in_valid(cx_vld), .vec(c),
        .out_valid(nf_vld), .res(f5), .zero(f_zero));

    bon_delay #(.W(193), .LAT(NORM_LAT)) u_d4 (
        .clk, .en, .d({r4, u4, deg4}), .q({r5, u5, deg5}));

    // Output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg   <= r5;
            u_reg   <= u5;
            f_reg   <= f5;
            deg_reg <= deg5 | f_zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= nf_vld;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.out_right_x = r_reg[0];
    assign result.out_right_y = r_reg[1];
    assign result.out_right_z = r_reg[2];
    assign result.out_up_x    = u_reg[0];
    assign result.out_up_y    = u_reg[1];
    assign result.out_up_z    = u_reg[2];
    assign result.out_fwd_x   = f_reg[0];
    assign result.out_fwd_y   = f_reg[1];
    assign result.out_fwd_z   = f_reg[2];
    assign result.degenerate  = deg_reg;
endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import bon_pkg::*;

    localparam int N_RAND = 1630;
    localparam int LIMIT = 400000;
    localparam int N_DIR = 18;
    localparam logic [31:0] P1 = 32'h40000000;
    localparam logic [31:0] M1 = 32'hC0000000;

    typedef struct {
        logic signed [31:0] f[6];
    } mat_in_t;

    typedef struct {
        logic signed [31:0] v[9];
        logic               deg;
    } basis_t;

    logic clk;
    logic rst_n;
    int   cycles = 0;
    int   errs = 0;
    int   rcvd = 0;
    bit   quiet = 0;
    bit   hold_done = 0;

    bon_in_if #(.IN_WIDTH(32)) item_ch ();
    bon_out_if                 res_ch ();

    rotation_basis_orthonormalizer_unit #(.IN_WIDTH(32)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch)
    );

    basis_t exp_basis_q[$];
    // per offered transaction: typed expectation if any
    bit     typed_has_q[$];
    basis_t typed_exp_q[$];

    // directed stimulus: right xyz, up xyz
    logic [31:0] dir_in [N_DIR][6] = '{
        '{32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0},                 // identity
        '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},                 // all zero
        '{32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0},                 // zero right
        '{32'd1, 32'd0, 32'd0, 32'd2, 32'd0, 32'd0},                 // parallel up
        '{32'hFFFFFFFF, 32'd0, 32'd0, 32'd0, 32'hFFFFFFFF, 32'd0},   // negated identity
        '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
          32'h80000000, 32'h80000000, 32'h7FFFFFFF},
        '{32'h80000000, 32'h80000000, 32'h80000000,
          32'h7FFFFFFF, 32'h80000000, 32'h80000000},
        '{32'h80000000, 32'd0, 32'd0, 32'd0, 32'h80000000, 32'd0},
        '{32'h7FFFFFFF, 32'd1, 32'd0, 32'd1, 32'h7FFFFFFF, 32'd0},
        '{32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},                 // zero up
        '{32'd5, 32'd7, 32'd9, 32'hFFFFFFFB, 32'hFFFFFFF9, 32'hFFFFFFF7}, // antiparallel
        '{32'h00020000, 32'd0, 32'd0, 32'd0, 32'h00030000, 32'd0},   // scaled basis
        '{32'h0000B505, 32'h0000B505, 32'd0, 32'hFFFF4AFB, 32'h0000B505, 32'd0},
        '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd1, 32'd0, 32'd0},
        '{32'd3, 32'd4, 32'd0, 32'd4, 32'd3, 32'd0},
        '{32'h55555555, 32'hAAAAAAAA, 32'h33333333,
          32'hCCCCCCCC, 32'h0F0F0F0F, 32'hF0F0F0F0},
        '{32'd0, 32'd0, 32'h7FFFFFFF, 32'd0, 32'd0, 32'h00000001}, // parallel, far scales
        '{32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd2}
    };
    bit dir_has [N_DIR] = '{1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    logic [31:0] dir_exp [5][10] = '{
        '{P1, 0, 0, 0, P1, 0, 0, 0, P1, 0},
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1},
        '{0, 0, 0, 0, P1, 0, 0, 0, 0, 1},
        '{P1, 0, 0, 0, 0, 0, 0, 0, 0, 1},
        '{M1, 0, 0, 0, M1, 0, 0, 0, P1, 0}
    };

    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned res = 0;
        longint unsigned b = 64'h4000000000000000;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    // Q4.60 -> Q2.30, half away from zero
    function automatic longint rnd30(longint x);
        longint unsigned q;
        q = ((x < 0 ? -x : x) + 64'd536870912) >> 30;
        return x < 0 ? -longint'(q) : longint'(q);
    endfunction

    // scale to unit length in Q2.30; returns 1 for a zero vector
    function automatic bit unitize(input longint v[3], output longint o[3]);
        longint unsigned m[3];
        longint unsigned mx = 0;
        longint unsigned sum = 0;
        longint unsigned n;
        longint unsigned q;
        int len = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = v[i] < 0 ? -v[i] : v[i];
            if (m[i] > mx)
                mx = m[i];
        end
        if (mx == 0)
        begin
            o = '{0, 0, 0};
            return 1;
        end
        while (len < 64 && (mx >> len) != 0)
            len++;
        for (int i = 0; i < 3; i++)
        begin
            if (len > 30)
                m[i] >>= (len - 30);
            else
                m[i] <<= (30 - len);
            sum += m[i] * m[i];
        end
        n = isqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << 30) + (n >> 1)) / n;
            o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 0;
    endfunction

    function automatic basis_t orthonormalize(mat_in_t x);
        longint ri[3], ui[3], r[3], un[3], w[3], u[3], c[3], fw[3];
        longint dot = 0;
        longint d;
        basis_t b;
        for (int i = 0; i < 3; i++)
        begin
            ri[i] = x.f[i];
            ui[i] = x.f[3 + i];
        end
        b.deg = unitize(ri, r);
        b.deg |= unitize(ui, un);
        for (int i = 0; i < 3; i++)
            dot += r[i] * un[i];
        d = rnd30(dot);
        for (int i = 0; i < 3; i++)
            w[i] = un[i] - rnd30(r[i] * d);
        b.deg |= unitize(w, u);
        c[0] = r[1] * u[2] - r[2] * u[1];
        c[1] = r[2] * u[0] - r[0] * u[2];
        c[2] = r[0] * u[1] - r[1] * u[0];
        b.deg |= unitize(c, fw);
        for (int i = 0; i < 3; i++)
        begin
            b.v[i] = r[i][31:0];
            b.v[3 + i] = u[i][31:0];
            b.v[6 + i] = fw[i][31:0];
        end
        return b;
    endfunction

    // clock
    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // input monitor: predict on every accepted transaction
    always @(posedge clk)
    begin
        if (rst_n && item_ch.valid && item_ch.ready)
        begin
            mat_in_t x;
            basis_t  p;
            bit      has;
            basis_t  t;
            x.f = '{item_ch.right_x, item_ch.right_y, item_ch.right_z,
                    item_ch.up_x, item_ch.up_y, item_ch.up_z};
            p = orthonormalize(x);
            has = typed_has_q.pop_front();
            t = typed_exp_q.pop_front();
            exp_basis_q.push_back(has ? t : p);
        end
    end

    // output monitor: compare with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            basis_t a;
            basis_t e;
            a.v = '{res_ch.out_right_x, res_ch.out_right_y, res_ch.out_right_z,
                    res_ch.out_up_x, res_ch.out_up_y, res_ch.out_up_z,
                    res_ch.out_fwd_x, res_ch.out_fwd_y, res_ch.out_fwd_z};
            a.deg = res_ch.degenerate;
            rcvd++;
            if (exp_basis_q.size() == 0)
            begin
                errs++;
                if (errs <= 10)
                    $display("unexpected result transaction at cycle %0d", cycles);
            end
            else
            begin
                e = exp_basis_q.pop_front();
                if (a.v != e.v || a.deg !== e.deg)
                begin
                    errs++;
                    if (errs <= 10)
                    begin
                        $display("mismatch at result %0d:", rcvd);
                        for (int i = 0; i < 9; i++)
                            if (a.v[i] !== e.v[i])
                                $display("  comp %0d exp %0d got %0d", i, e.v[i], a.v[i]);
                        if (a.deg !== e.deg)
                            $display("  degenerate exp %0b got %0b", e.deg, a.deg);
                    end
                end
            end
        end
    end

    // result ready: random stalls, one long hold-off to back up the pipe
    initial
    begin
        int n;
        res_ch.ready <= 0;
        @(posedge rst_n);
        forever
        begin
            if (!hold_done && rcvd >= 300)
            begin
                hold_done = 1;
                n = 0;
                res_ch.ready <= 0;
                while (n < 400)
                begin
                    @(posedge clk);
                    n++;
                end
            end
            else if (quiet || $urandom_range(0, 2) != 0)
            begin
                res_ch.ready <= 1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                res_ch.ready <= 0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end
    end

    task automatic offer(mat_in_t x, bit has, basis_t t);
        typed_has_q.push_back(has);
        typed_exp_q.push_back(t);
        item_ch.valid <= 1;
        item_ch.right_x <= x.f[0];
        item_ch.right_y <= x.f[1];
        item_ch.right_z <= x.f[2];
        item_ch.up_x <= x.f[3];
        item_ch.up_y <= x.f[4];
        item_ch.up_z <= x.f[5];
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        // sender idle burst
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            item_ch.valid <= 0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] small_val();
        return 32'($signed($urandom_range(0, 2000)) - 1000);
    endfunction

    // stimulus
    initial
    begin
        mat_in_t x;
        basis_t  t;
        int      k;
        int      kind;
        rst_n = 0;
        item_ch.valid <= 0;
        item_ch.right_x <= 0;
        item_ch.right_y <= 0;
        item_ch.right_z <= 0;
        item_ch.up_x <= 0;
        item_ch.up_y <= 0;
        item_ch.up_z <= 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < N_DIR; i++)
        begin
            for (int j = 0; j < 6; j++)
                x.f[j] = dir_in[i][j];
            if (dir_has[i])
            begin
                for (int j = 0; j < 9; j++)
                    t.v[j] = dir_exp[i][j];
                t.deg = dir_exp[i][9][0];
            end
            offer(x, dir_has[i], t);
        end

        // random matrices
        for (int i = 0; i < N_RAND; i++)
        begin
            if (i == 800)
            begin
                // drain before continuing
                item_ch.valid <= 0;
                @(posedge clk);
                while (exp_basis_q.size() != 0)
                    @(posedge clk);
            end
            if (i == N_RAND - 200)
                quiet = 1;
            kind = $urandom_range(0, 9);
            for (int j = 0; j < 6; j++)
                x.f[j] = (kind < 4) ? $urandom() : small_val();
            case (kind)
                6:
                begin
                    // parallel up, or up scaled from right with a random sign per component
                    k = $urandom_range(1, 50);
                    for (int j = 0; j < 3; j++)
                        x.f[3 + j] = ($urandom_range(0, 1) ? k : -k) * x.f[j];
                    if ($urandom_range(0, 1))
                        for (int j = 0; j < 3; j++)
                            x.f[3 + j] = k * x.f[j];
                end
                7:
                begin
                    // a zero row, sometimes both
                    k = $urandom_range(0, 2);
                    if (k != 1)
                        for (int j = 0; j < 3; j++)
                            x.f[j] = 0;
                    if (k != 0)
                        for (int j = 3; j < 6; j++)
                            x.f[j] = 0;
                end
                8:
                begin
                    // scaled near-orthogonal rows
                    k = $urandom_range(1, 30000);
                    x.f[0] = k * x.f[0] / 16;
                    x.f[1] = k * x.f[1] / 16;
                    x.f[4] = x.f[0] + $signed(small_val()) / 64;
                    x.f[3] = -x.f[1] + $signed(small_val()) / 64;
                end
                default:
                begin
                end
            endcase
            offer(x, 0, t);
        end
        item_ch.valid <= 0;

        while (exp_basis_q.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        if (errs == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
hdl/bon_pkg.sv
hdl/bon_in_if.sv
hdl/bon_out_if.sv
hdl/bon_delay.sv
hdl/bon_norm3.sv
hdl/bon_proj.sv
hdl/bon_cross.sv
hdl/rotation_basis_orthonormalizer_unit.sv
tb/tb.sv
